>>> rtl/gbs_pkg.sv
// ----------------------------------------------------------------------------
// gbs_pkg
// Shared constants and types for the greedy box suppression block.
// ----------------------------------------------------------------------------
package gbs_pkg;

  localparam int MAX_KEPT = 256;
  localparam int CNT_W    = $clog2(MAX_KEPT + 1);
  localparam int STEP_W   = $clog2(MAX_KEPT);

  localparam int IN_W       = 72;
  localparam int OUT_W      = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_OVERLAP_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLASS_AGNOSTIC    = 2'd1;

  localparam logic [15:0] THRESHOLD_RESET = 16'd29491;

  typedef struct packed {
    logic [15:0] left;
    logic [15:0] top;
    logic [15:0] width;
    logic [15:0] height;
    logic [31:0] area;
    logic [7:0]  label;
  } kept_t;

  typedef struct packed {
    logic busy;
    logic hit;
  } iou_stat_t;

endpackage

>>> rtl/gbs_cell.sv
// ----------------------------------------------------------------------------
// gbs_cell
// One cell of the kept-box chain; takes its neighbor's box on every shift.
// ----------------------------------------------------------------------------
module gbs_cell (
  input  logic          clk,
  input  logic          shift,
  input  gbs_pkg::kept_t d,
  output gbs_pkg::kept_t q
);
  import gbs_pkg::*;

  always_ff @(posedge clk) begin
    if (shift) begin
      q <= d;
    end
  end

endmodule

>>> rtl/gbs_iou.sv
// ----------------------------------------------------------------------------
// gbs_iou
// Five-stage overlap test of the candidate against one kept box per cycle.
// ----------------------------------------------------------------------------
module gbs_iou (
  input  logic             clk,
  input  logic             rst,
  input  logic             tap_valid,
  input  gbs_pkg::kept_t   kept,
  input  gbs_pkg::kept_t   cand,
  input  logic [15:0]      threshold,
  input  logic             agnostic,
  output gbs_pkg::iou_stat_t stat
);
  import gbs_pkg::*;

  function automatic logic [15:0] overlap_len(input logic [15:0] a0, input logic [15:0] alen,
                                              input logic [15:0] b0, input logic [15:0] blen);
    logic [16:0] a1;
    logic [16:0] b1;
    logic [16:0] lo;
    logic [16:0] hi;
    a1 = {1'b0, a0} + {1'b0, alen};
    b1 = {1'b0, b0} + {1'b0, blen};
    lo = (a0 > b0) ? {1'b0, a0} : {1'b0, b0};
    hi = (a1 < b1) ? a1 : b1;
    return (hi > lo) ? 16'(hi - lo) : 16'd0;
  endfunction

  logic        v1, v2, v3, v4, v5;
  logic [15:0] iw1, ih1;
  logic [31:0] karea1;
  logic [31:0] inter2, inter3, inter4;
  logic [32:0] sum2;
  logic [32:0] uni3;
  logic [48:0] prod4;
  logic        hit5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      hit5 <= 1'b0;
    end else begin
      v1 <= tap_valid && (agnostic || (kept.label == cand.label));
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      hit5 <= v4 && ({1'b0, inter4, 16'd0} > prod4);
    end
  end

  always_ff @(posedge clk) begin
    iw1    <= overlap_len(cand.left, cand.width, kept.left, kept.width);
    ih1    <= overlap_len(cand.top, cand.height, kept.top, kept.height);
    karea1 <= kept.area;
    inter2 <= iw1 * ih1;
    sum2   <= {1'b0, cand.area} + {1'b0, karea1};
    inter3 <= inter2;
    uni3   <= sum2 - {1'b0, inter2};
    inter4 <= inter3;
    prod4  <= {33'd0, threshold} * {16'd0, uni3};
  end

  assign stat.busy = v1 | v2 | v3 | v4 | v5;
  assign stat.hit  = v5 & hit5;

endmodule

>>> rtl/greedy_box_suppression.sv
// ----------------------------------------------------------------------------
// greedy_box_suppression
// Greedy IoU suppression of score-sorted boxes against a chain of kept boxes.
// ----------------------------------------------------------------------------
// A request scans one full rotation of the chain while the kept list holds a box, then
// drains the five-stage IoU pipeline (the drain ends early when the last taps skip other
// classes); on an empty list it goes straight to the result.
// Only one request is in flight at a time; a stalled result holds off the next request.
// Reset clears the kept count, the frame position and the registers, not the chain.
module greedy_box_suppression (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // box_left, box_top, box_width, box_height, class_label
  input  logic [gbs_pkg::IN_W-1:0]      s_tdata,
  // first_of_frame
  input  logic                          s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // keep, box_index, list_overflow
  output logic [gbs_pkg::OUT_W-1:0]     m_tdata,
  input  logic                          cfg_wr_en,
  input  logic [gbs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gbs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import gbs_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  localparam logic [CNT_W:0]    MAX_KEPT_SUM = (CNT_W + 1)'(MAX_KEPT);
  localparam logic [CNT_W-1:0]  MAX_KEPT_CNT = CNT_W'(MAX_KEPT);
  localparam logic [STEP_W-1:0] LAST_STEP    = STEP_W'(MAX_KEPT - 1);

  state_t             state;
  logic [15:0]        threshold;
  logic               agnostic;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic [15:0]        frame_pos;
  logic [15:0]        index;
  logic [15:0]        index_next;
  logic [STEP_W-1:0]  step;
  logic               suppress;
  kept_t              cand;
  kept_t              chain [MAX_KEPT];
  kept_t              head_in;
  logic               shift;
  logic               out_free;
  logic               list_full;
  logic               insert;
  logic               tap_valid;
  iou_stat_t          stat;

  assign s_tready   = (state == ST_IDLE) && !rst;
  assign out_free   = !m_tvalid || m_tready;
  assign list_full  = (count == MAX_KEPT_CNT);
  assign insert     = (state == ST_FINISH) && out_free && !suppress && !list_full;
  assign shift      = (state == ST_SCAN) || insert;
  assign head_in    = insert ? cand : chain[MAX_KEPT-1];
  assign tap_valid  = (state == ST_SCAN) &&
                      (((CNT_W + 1)'(step) + (CNT_W + 1)'(count)) >= MAX_KEPT_SUM);
  assign count_next = s_tuser ? '0 : count;
  assign index_next = s_tuser ? 16'd0 : frame_pos;

  gbs_cell u_cell_head (
    .clk   (clk),
    .shift (shift),
    .d     (head_in),
    .q     (chain[0])
  );

  for (genvar i = 1; i < MAX_KEPT; i++) begin : g_chain
    gbs_cell u_cell (
      .clk   (clk),
      .shift (shift),
      .d     (chain[i-1]),
      .q     (chain[i])
    );
  end

  gbs_iou u_iou (
    .clk       (clk),
    .rst       (rst),
    .tap_valid (tap_valid),
    .kept      (chain[MAX_KEPT-1]),
    .cand      (cand),
    .threshold (threshold),
    .agnostic  (agnostic),
    .stat      (stat)
  );

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      cand.left   <= s_tdata[15:0];
      cand.top    <= s_tdata[31:16];
      cand.width  <= s_tdata[47:32];
      cand.height <= s_tdata[63:48];
      cand.label  <= s_tdata[71:64];
      cand.area   <= s_tdata[47:32] * s_tdata[63:48];
      index       <= index_next;
    end
    if ((state == ST_FINISH) && out_free) begin
      m_tdata <= {6'd0, (!suppress && list_full), index, !suppress};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      threshold <= THRESHOLD_RESET;
      agnostic  <= 1'b0;
      count     <= '0;
      frame_pos <= 16'd0;
      step      <= '0;
      suppress  <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (cfg_wr_en && (cfg_index == REG_OVERLAP_THRESHOLD)) begin
        threshold <= cfg_data;
      end
      if (cfg_wr_en && (cfg_index == REG_CLASS_AGNOSTIC)) begin
        agnostic <= cfg_data[0];
      end
      if ((state == ST_FINISH) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (stat.hit) begin
        suppress <= 1'b1;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            count     <= count_next;
            frame_pos <= index_next + 16'd1;
            suppress  <= 1'b0;
            step      <= '0;
            state     <= (count_next == '0) ? ST_FINISH : ST_SCAN;
          end
        end
        ST_SCAN: begin
          step <= step + 1'b1;
          if (step == LAST_STEP) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!stat.busy) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            if (insert) begin
              count <= count + 1'b1;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> verif/greedy_box_suppression_tb.sv
// ----------------------------------------------------------------------------
// greedy_box_suppression_tb
// Self-checking testbench for the greedy box suppression block. A built-in
// predictor keeps its own kept-box list and registers, and computes keep,
// index and overflow for every accepted request. A sink process compares each
// result with the oldest prediction. The run covers directed corner boxes,
// threshold and class-agnostic extremes, a full kept list, a long output stall
// and random frames of overlapping boxes with random idling on both sides.
// ----------------------------------------------------------------------------
module greedy_box_suppression_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gbs_pkg::*;

  localparam int CYCLE_LIMIT     = 1_200_000;
  localparam int MAX_GAP         = 13;
  localparam int HOLD_OFF_CYCLES = 900;

  typedef struct {
    bit        first;
    bit [15:0] left;
    bit [15:0] top;
    bit [15:0] wid;
    bit [15:0] hgt;
    bit [7:0]  label;
  } box_t;

  typedef struct {
    bit        keep;
    bit [15:0] index;
    bit        overflow;
  } verdict_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_W-1:0]       s_tdata;
  logic                  s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_W-1:0]      m_tdata;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bit [15:0] threshold_q  = THRESHOLD_RESET;
  bit        agnostic_q   = 1'b0;
  box_t      kept_box [MAX_KEPT];
  bit [31:0] kept_area[MAX_KEPT];
  int        kept_n       = 0;
  bit [15:0] next_index   = '0;

  verdict_t  pending_verdicts[$];
  int        errors          = 0;
  int        results_seen    = 0;
  int        kept_total      = 0;
  int        suppressed_total = 0;
  int        overflow_total  = 0;
  bit        steady          = 1'b0;
  int        hold_off        = 0;
  int        cycle_count     = 0;

  greedy_box_suppression u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  function automatic box_t mk(bit first, bit [15:0] left, bit [15:0] top,
                              bit [15:0] wid, bit [15:0] hgt, bit [7:0] label);
    box_t b;
    b.first = first;
    b.left  = left;
    b.top   = top;
    b.wid   = wid;
    b.hgt   = hgt;
    b.label = label;
    return b;
  endfunction

  // Edges are carried at 17 bits so that boxes reaching past 0xFFFF still overlap.
  function automatic bit [16:0] span_overlap(bit [15:0] a0, bit [15:0] alen,
                                             bit [15:0] b0, bit [15:0] blen);
    bit [16:0] a1, b1, lo, hi;
    a1 = a0 + alen;
    b1 = b0 + blen;
    lo = (a0 > b0) ? a0 : b0;
    hi = (a1 < b1) ? a1 : b1;
    return (hi > lo) ? hi - lo : 17'd0;
  endfunction

  function automatic verdict_t suppress_box(box_t b);
    verdict_t  v;
    bit [63:0] area, inter, uni_area;
    bit [16:0] iw, ih;
    if (b.first) begin
      kept_n     = 0;
      next_index = '0;
    end
    v.index    = next_index;
    next_index = next_index + 16'd1;
    v.keep     = 1'b1;
    v.overflow = 1'b0;
    area = 64'(b.wid) * 64'(b.hgt);
    for (int j = 0; j < kept_n; j++) begin
      if (!agnostic_q && kept_box[j].label != b.label) continue;
      iw       = span_overlap(b.left, b.wid, kept_box[j].left, kept_box[j].wid);
      ih       = span_overlap(b.top, b.hgt, kept_box[j].top, kept_box[j].hgt);
      inter    = 64'(iw) * 64'(ih);
      uni_area = area + 64'(kept_area[j]) - inter;
      if ((inter << 16) > 64'(threshold_q) * uni_area) v.keep = 1'b0;
    end
    if (v.keep) begin
      if (kept_n < MAX_KEPT) begin
        kept_box[kept_n]  = b;
        kept_area[kept_n] = area[31:0];
        kept_n++;
      end else begin
        v.overflow = 1'b1;
      end
    end
    return v;
  endfunction

  function automatic int draw_gap();
    if (steady || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, MAX_GAP);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    if (errors <= 20)
      $display("mismatch at %0t, result %0d: %s got %0d expected %0d",
               $time, results_seen, what, got, want);
  endtask

  task automatic send_box(box_t b);
    int       gap;
    verdict_t v;
    gap = draw_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= b.first;
    s_tdata  <= {b.label, b.hgt, b.wid, b.top, b.left};
    do @(posedge clk); while (!s_tready);
    v = suppress_box(b);
    pending_verdicts = {pending_verdicts, v};
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (MAX_KEPT + 16) @(posedge clk);
  endtask

  task automatic set_config(bit [15:0] threshold, bit agnostic);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_OVERLAP_THRESHOLD;
    cfg_data  <= threshold;
    @(posedge clk);
    cfg_index <= REG_CLASS_AGNOSTIC;
    cfg_data  <= CFG_DATA_W'(agnostic);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    threshold_q = threshold;
    agnostic_q  = agnostic;
  endtask

  initial begin : result_sink
    int       gap;
    verdict_t want;
    gap      = 0;
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        results_seen++;
        if (pending_verdicts.size() == 0) begin
          report_mismatch("result with no request pending", 1, 0);
        end else begin
          want = pending_verdicts.pop_front();
          if (m_tdata[0] !== want.keep)
            report_mismatch("keep", int'(m_tdata[0]), int'(want.keep));
          if (m_tdata[16:1] !== want.index)
            report_mismatch("box_index", int'(m_tdata[16:1]), int'(want.index));
          if (m_tdata[17] !== want.overflow)
            report_mismatch("list_overflow", int'(m_tdata[17]), int'(want.overflow));
          if (want.keep) kept_total++;
          else suppressed_total++;
          if (want.overflow) overflow_total++;
        end
        gap = draw_gap();
      end else if (gap > 0) begin
        gap--;
      end
      if (hold_off > 0) begin
        hold_off--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= (gap == 0);
      end
    end
  end

  task automatic test_directed();
    send_box(mk(1, 16'h0100, 16'h0100, 16'h0400, 16'h0400, 8'd1));
    send_box(mk(0, 16'h0100, 16'h0100, 16'h0400, 16'h0400, 8'd1));
    send_box(mk(0, 16'h0100, 16'h0100, 16'h0400, 16'h0400, 8'd2));
    // Touches the first box on its right edge only.
    send_box(mk(0, 16'h0500, 16'h0100, 16'h0400, 16'h0400, 8'd1));
    send_box(mk(0, 16'h0180, 16'h0100, 16'h0400, 16'h0400, 8'd1));
    send_box(mk(0, 16'h0300, 16'h0100, 16'h0400, 16'h0400, 8'd1));
    // Two empty boxes at one spot give a zero union.
    send_box(mk(0, 16'h2000, 16'h2000, 16'h0000, 16'h0000, 8'd3));
    send_box(mk(0, 16'h2000, 16'h2000, 16'h0000, 16'h0000, 8'd3));
    send_box(mk(0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF));
    send_box(mk(0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF));
    send_box(mk(0, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 8'hFF));
    send_box(mk(0, 16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF, 8'hFF));
    send_box(mk(0, 16'h0100, 16'h0100, 16'h0400, 16'h0400, 8'h00));
    send_box(mk(1, 16'h0100, 16'h0100, 16'h0400, 16'h0400, 8'd1));
    send_box(mk(0, 16'h0100, 16'h0100, 16'h0400, 16'h0400, 8'd1));
    drain();
  endtask

  task automatic test_thresholds();
    set_config(16'h0000, 1'b0);
    send_box(mk(1, 16'h1000, 16'h1000, 16'h0200, 16'h0200, 8'd4));
    send_box(mk(0, 16'h1200, 16'h1000, 16'h0200, 16'h0200, 8'd4));
    send_box(mk(0, 16'h11FF, 16'h11FF, 16'h0200, 16'h0200, 8'd4));
    drain();
    set_config(16'hFFFF, 1'b0);
    send_box(mk(1, 16'h1000, 16'h1000, 16'h0200, 16'h0200, 8'd4));
    send_box(mk(0, 16'h1000, 16'h1000, 16'h0200, 16'h0200, 8'd4));
    send_box(mk(0, 16'h1000, 16'h1000, 16'h0201, 16'h0200, 8'd4));
    drain();
    set_config(16'h8000, 1'b1);
    send_box(mk(1, 16'h1000, 16'h1000, 16'h0200, 16'h0200, 8'd5));
    send_box(mk(0, 16'h1000, 16'h1000, 16'h0200, 16'h0200, 8'd9));
    drain();
  endtask

  task automatic test_list_overflow();
    set_config(THRESHOLD_RESET, 1'b0);
    steady = 1'b1;
    for (int k = 0; k < MAX_KEPT + 2; k++)
      send_box(mk(k == 0, 16'(k * 32), 16'h0040, 16'h0010, 16'h0010, 8'd7));
    send_box(mk(0, 16'h0000, 16'h0040, 16'h0010, 16'h0010, 8'd7));
    send_box(mk(0, 16'(MAX_KEPT * 32), 16'h0040, 16'h0010, 16'h0010, 8'd7));
    drain();
    steady = 1'b0;
  endtask

  task automatic test_backpressure();
    hold_off = HOLD_OFF_CYCLES;
    for (int i = 0; i < 8; i++)
      send_box(mk(i == 0, 16'(16'h0400 + 16'($urandom_range(0, 256))),
                  16'h0400, 16'h0300, 16'h0300, 8'($urandom_range(0, 1))));
    drain();
  endtask

  function automatic box_t random_box(const ref box_t hist[$]);
    box_t b, p;
    int   r;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      b = mk(1'($urandom_range(0, 1)), 16'($urandom()), 16'($urandom()),
             16'($urandom()), 16'($urandom()), 8'($urandom()));
    end else if (r < 30 || hist.size() == 0) begin
      b = mk(1'b0, 16'($urandom_range(0, 16'h3000)), 16'($urandom_range(0, 16'h3000)),
             16'($urandom_range(0, 16'h0800)), 16'($urandom_range(0, 16'h0800)),
             8'($urandom_range(0, 3)));
    end else begin
      p = hist[$urandom_range(0, hist.size() - 1)];
      b = p;
      b.first = 1'b0;
      b.left  = p.left + 16'($urandom_range(0, 64)) - 16'd32;
      b.top   = p.top  + 16'($urandom_range(0, 64)) - 16'd32;
      b.wid   = p.wid  + 16'($urandom_range(0, 64)) - 16'd32;
      b.hgt   = p.hgt  + 16'($urandom_range(0, 64)) - 16'd32;
      if ($urandom_range(0, 4) == 0) b.label = 8'($urandom_range(0, 3));
    end
    return b;
  endfunction

  task automatic test_random(int n_items);
    int        sent, phase_end, frame_len;
    bit [15:0] threshold;
    box_t      hist[$];
    box_t      b;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(0, 4))
        0:       threshold = 16'h0000;
        1:       threshold = 16'hFFFF;
        2:       threshold = THRESHOLD_RESET;
        default: threshold = 16'($urandom_range(0, 16'hFFFF));
      endcase
      set_config(threshold, 1'($urandom_range(0, 1)));
      steady    = ($urandom_range(0, 3) == 0);
      phase_end = sent + $urandom_range(60, 120);
      while (sent < phase_end && sent < n_items) begin
        frame_len = $urandom_range(1, 40);
        hist.delete();
        for (int i = 0; i < frame_len && sent < n_items; i++) begin
          b = random_box(hist);
          if (i == 0) b.first = 1'b1;
          if (b.first) hist.delete();
          send_box(b);
          hist = {hist, b};
          sent++;
        end
      end
      drain();
    end
    steady = 1'b0;
  endtask

  initial begin : stimulus
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = REG_OVERLAP_THRESHOLD;
    cfg_data  = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_thresholds();
    test_list_overflow();
    test_backpressure();
    test_random(500);

    $display("summary: %0d results checked across directed, threshold, full-list,",
             results_seen);
    $display("summary: stall and random phases; %0d kept, %0d suppressed, %0d overflowed",
             kept_total, suppressed_total, overflow_total);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
